### rtl/core/climate_hysteresis_controller_unit_assert.svh
// Assertion macros shared by the controller RTL.
`ifndef CLIMATE_HYSTERESIS_CONTROLLER_UNIT_ASSERT_SVH
`define CLIMATE_HYSTERESIS_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CHCU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("controller assertion failed");

// Next-cycle implication, disabled while reset is low.
`define CHCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("controller assertion failed");

`endif

### rtl/core/chcu_pkg.sv
`default_nettype none

package chcu_pkg;

    // Sample scaling constants.
    localparam int unsigned SAMPLE_FULL_SCALE = 4095;
    localparam int unsigned READING_TOP       = 99;
    localparam int unsigned SAMPLE_W          = 12;
    localparam int unsigned FIELD_W           = 7;
    localparam int unsigned LIMIT_W           = 7;

    // Scaling works on x = raw * READING_TOP + SAMPLE_FULL_SCALE / 2.
    localparam int unsigned HALF_SCALE = SAMPLE_FULL_SCALE / 2;
    localparam int unsigned X_MAX      = (2**SAMPLE_W - 1) * READING_TOP + HALF_SCALE;
    localparam int unsigned X_W        = $clog2(X_MAX + 1);

    // Reciprocal of the full scale; the quotient estimate is low by at most one.
    localparam int unsigned RECIP_SHIFT = X_W;
    localparam int unsigned RECIP_M     = (2**X_W) / SAMPLE_FULL_SCALE;
    localparam int unsigned M_W         = $clog2(RECIP_M + 1);
    localparam int unsigned P_W         = X_W + M_W;
    localparam int unsigned Q_MAX       = X_MAX / SAMPLE_FULL_SCALE;
    localparam int unsigned Q_W         = $clog2(Q_MAX + 2);
    localparam int unsigned RD_W        = $clog2(READING_TOP + 1);

    // Threshold arithmetic widths.
    localparam int unsigned TH_W     = 8;
    localparam int unsigned SPAN3_W  = 9;
    localparam int unsigned SPAN9_W  = 11;
    localparam int unsigned CMP_W    = (RD_W > TH_W) ? RD_W : TH_W;

    // Division by ten as multiply and shift, exact below 16384.
    localparam int unsigned DIV10_MUL   = 6554;
    localparam int unsigned DIV10_SHIFT = 16;
    localparam int unsigned DIV10_P_W   = 24;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMID_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMID_HIGH = 2'd3;

    // Limit values after reset.
    localparam logic [LIMIT_W-1:0] RST_TEMP_LOW   = 7'd10;
    localparam logic [LIMIT_W-1:0] RST_TEMP_HIGH  = 7'd26;
    localparam logic [LIMIT_W-1:0] RST_HUMID_LOW  = 7'd60;
    localparam logic [LIMIT_W-1:0] RST_HUMID_HIGH = 7'd83;

    // Load strobes of the three scaling stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pipe_en;

    // Limits and precomputed switching points.
    typedef struct packed {
        logic [LIMIT_W-1:0] temp_low;
        logic [LIMIT_W-1:0] temp_high;
        logic [LIMIT_W-1:0] humid_low;
        logic [TH_W-1:0]    heat_off;
        logic [TH_W-1:0]    cool_off;
        logic [TH_W-1:0]    irr_off;
        logic [TH_W-1:0]    temp_alert_lo;
        logic [TH_W-1:0]    temp_alert_hi;
        logic [TH_W-1:0]    humid_alert;
    } t_thresh;

endpackage

`default_nettype wire

### rtl/core/chcu_scale.sv
`default_nettype none

module chcu_scale (
    input  wire logic                         i_clk,
    input  wire chcu_pkg::t_pipe_en           i_en,
    input  wire logic [chcu_pkg::SAMPLE_W-1:0] i_raw,
    output logic      [chcu_pkg::RD_W-1:0]     o_scaled
);

    logic [chcu_pkg::SAMPLE_W-1:0] r_raw;
    logic [chcu_pkg::X_W-1:0]      r_x;
    logic [chcu_pkg::X_W-1:0]      n_x;
    logic [chcu_pkg::X_W-1:0]      r_x3;
    logic [chcu_pkg::Q_W-1:0]      r_q0;
    logic [chcu_pkg::Q_W-1:0]      n_q0;
    logic [chcu_pkg::P_W-1:0]      w_prod;
    logic [chcu_pkg::X_W:0]        w_back;
    logic [chcu_pkg::X_W:0]        w_rem;
    logic [chcu_pkg::Q_W-1:0]      w_q;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_raw <= i_raw;
        end
    end

    // Scale by the reading top and add half of full scale for rounding.
    assign n_x = chcu_pkg::X_W'(r_raw) * chcu_pkg::X_W'(chcu_pkg::READING_TOP)
               + chcu_pkg::X_W'(chcu_pkg::HALF_SCALE);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_x <= n_x;
        end
    end

    // Quotient estimate through the reciprocal of full scale.
    assign w_prod = chcu_pkg::P_W'(r_x) * chcu_pkg::P_W'(chcu_pkg::RECIP_M);
    assign n_q0   = chcu_pkg::Q_W'(w_prod >> chcu_pkg::RECIP_SHIFT);

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_q0 <= n_q0;
            r_x3 <= r_x;
        end
    end

    // One correction step, then saturate at the reading top.
    assign w_back = (chcu_pkg::X_W + 1)'(r_q0) * (chcu_pkg::X_W + 1)'(chcu_pkg::SAMPLE_FULL_SCALE);
    assign w_rem  = (chcu_pkg::X_W + 1)'(r_x3) - w_back;
    assign w_q    = (w_rem >= (chcu_pkg::X_W + 1)'(chcu_pkg::SAMPLE_FULL_SCALE))
                  ? (r_q0 + chcu_pkg::Q_W'(1)) : r_q0;

    always_comb begin
        if (w_q > chcu_pkg::Q_W'(chcu_pkg::READING_TOP)) begin
            o_scaled = chcu_pkg::RD_W'(chcu_pkg::READING_TOP);
        end else begin
            o_scaled = chcu_pkg::RD_W'(w_q);
        end
    end

endmodule

`default_nettype wire

### rtl/core/chcu_limits.sv
`default_nettype none

module chcu_limits (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [chcu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [chcu_pkg::LIMIT_W-1:0]   i_cfg_data,
    output chcu_pkg::t_thresh                   o_thresh
);

    logic [chcu_pkg::LIMIT_W-1:0]   r_temp_low;
    logic [chcu_pkg::LIMIT_W-1:0]   r_temp_high;
    logic [chcu_pkg::LIMIT_W-1:0]   r_humid_low;
    logic [chcu_pkg::LIMIT_W-1:0]   r_humid_high;
    logic [chcu_pkg::LIMIT_W-1:0]   r_tspan;
    logic [chcu_pkg::LIMIT_W-1:0]   r_hspan;
    logic [chcu_pkg::SPAN9_W-1:0]   r_tspan9;
    logic [chcu_pkg::SPAN9_W-1:0]   r_hspan9;
    logic [chcu_pkg::LIMIT_W-1:0]   n_tspan;
    logic [chcu_pkg::LIMIT_W-1:0]   n_hspan;
    logic [chcu_pkg::DIV10_P_W-1:0] w_t910_p;
    logic [chcu_pkg::DIV10_P_W-1:0] w_h910_p;
    logic [chcu_pkg::LIMIT_W-1:0]   w_t910;
    logic [chcu_pkg::LIMIT_W-1:0]   w_h910;
    logic [chcu_pkg::SPAN3_W-1:0]   w_hspan3;
    chcu_pkg::t_thresh              r_th;
    chcu_pkg::t_thresh              n_th;

    // Configuration registers; the write data keeps its low seven bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_low   <= chcu_pkg::RST_TEMP_LOW;
            r_temp_high  <= chcu_pkg::RST_TEMP_HIGH;
            r_humid_low  <= chcu_pkg::RST_HUMID_LOW;
            r_humid_high <= chcu_pkg::RST_HUMID_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                chcu_pkg::CFG_TEMP_LOW:   r_temp_low   <= i_cfg_data;
                chcu_pkg::CFG_TEMP_HIGH:  r_temp_high  <= i_cfg_data;
                chcu_pkg::CFG_HUMID_LOW:  r_humid_low  <= i_cfg_data;
                chcu_pkg::CFG_HUMID_HIGH: r_humid_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Band spans, clamped to zero when the limits are inverted.
    assign n_tspan = (r_temp_high >= r_temp_low) ? (r_temp_high - r_temp_low) : '0;
    assign n_hspan = (r_humid_high >= r_humid_low) ? (r_humid_high - r_humid_low) : '0;

    always_ff @(posedge i_clk) begin
        r_tspan  <= n_tspan;
        r_hspan  <= n_hspan;
        r_tspan9 <= (chcu_pkg::SPAN9_W'(n_tspan) << 3) + chcu_pkg::SPAN9_W'(n_tspan);
        r_hspan9 <= (chcu_pkg::SPAN9_W'(n_hspan) << 3) + chcu_pkg::SPAN9_W'(n_hspan);
    end

    // Nine tenths of each span through the reciprocal of ten.
    assign w_t910_p = chcu_pkg::DIV10_P_W'(r_tspan9) * chcu_pkg::DIV10_P_W'(chcu_pkg::DIV10_MUL);
    assign w_h910_p = chcu_pkg::DIV10_P_W'(r_hspan9) * chcu_pkg::DIV10_P_W'(chcu_pkg::DIV10_MUL);
    assign w_t910   = chcu_pkg::LIMIT_W'(w_t910_p >> chcu_pkg::DIV10_SHIFT);
    assign w_h910   = chcu_pkg::LIMIT_W'(w_h910_p >> chcu_pkg::DIV10_SHIFT);
    assign w_hspan3 = (chcu_pkg::SPAN3_W'(r_hspan) << 1) + chcu_pkg::SPAN3_W'(r_hspan);

    // Switching points for the hysteresis and alert compares.
    always_comb begin
        n_th.temp_low      = r_temp_low;
        n_th.temp_high     = r_temp_high;
        n_th.humid_low     = r_humid_low;
        n_th.heat_off      = chcu_pkg::TH_W'(r_temp_low) + chcu_pkg::TH_W'(r_tspan >> 2);
        n_th.cool_off      = chcu_pkg::TH_W'(r_temp_high) - chcu_pkg::TH_W'(r_tspan >> 2);
        n_th.irr_off       = chcu_pkg::TH_W'(r_humid_low) + chcu_pkg::TH_W'(w_hspan3 >> 2);
        n_th.temp_alert_lo = chcu_pkg::TH_W'(r_temp_high) - chcu_pkg::TH_W'(w_t910);
        n_th.temp_alert_hi = chcu_pkg::TH_W'(r_temp_low) + chcu_pkg::TH_W'(w_t910);
        n_th.humid_alert   = chcu_pkg::TH_W'(r_humid_high) - chcu_pkg::TH_W'(w_h910);
    end

    always_ff @(posedge i_clk) begin
        r_th <= n_th;
    end

    assign o_thresh = r_th;

endmodule

`default_nettype wire

### rtl/core/chcu_decide.sv
`default_nettype none

module chcu_decide (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_load,
    input  wire logic [chcu_pkg::RD_W-1:0] i_temp,
    input  wire logic [chcu_pkg::RD_W-1:0] i_humid,
    input  wire chcu_pkg::t_thresh         i_thresh,
    output logic                           o_irrigate_on,
    output logic                           o_cool_on,
    output logic                           o_heat_on,
    output logic                           o_alert_on,
    output logic [chcu_pkg::FIELD_W-1:0]   o_temp_scaled,
    output logic [chcu_pkg::FIELD_W-1:0]   o_humid_scaled
);

    logic [chcu_pkg::CMP_W-1:0] w_t;
    logic [chcu_pkg::CMP_W-1:0] w_h;
    logic [chcu_pkg::CMP_W-1:0] w_tlo;
    logic [chcu_pkg::CMP_W-1:0] w_thi;
    logic [chcu_pkg::CMP_W-1:0] w_hlo;
    logic                       r_irr;
    logic                       r_cool;
    logic                       r_heat;
    logic                       n_irr;
    logic                       n_cool;
    logic                       n_heat;
    logic                       n_alert;
    logic                       r_alert;
    logic [chcu_pkg::FIELD_W-1:0] r_temp_scaled;
    logic [chcu_pkg::FIELD_W-1:0] r_humid_scaled;

    assign w_t   = chcu_pkg::CMP_W'(i_temp);
    assign w_h   = chcu_pkg::CMP_W'(i_humid);
    assign w_tlo = chcu_pkg::CMP_W'(i_thresh.temp_low);
    assign w_thi = chcu_pkg::CMP_W'(i_thresh.temp_high);
    assign w_hlo = chcu_pkg::CMP_W'(i_thresh.humid_low);

    // Hysteresis: switch on at the limit, off past the off point (irrigation at it), else hold.
    always_comb begin
        n_irr = r_irr;
        if (w_h <= w_hlo) begin
            n_irr = 1'b1;
        end else if (w_h >= chcu_pkg::CMP_W'(i_thresh.irr_off)) begin
            n_irr = 1'b0;
        end

        n_cool = r_cool;
        if (w_t >= w_thi) begin
            n_cool = 1'b1;
        end else if (w_t < chcu_pkg::CMP_W'(i_thresh.cool_off)) begin
            n_cool = 1'b0;
        end

        n_heat = r_heat;
        if (w_t <= w_tlo) begin
            n_heat = 1'b1;
        end else if (w_t > chcu_pkg::CMP_W'(i_thresh.heat_off)) begin
            n_heat = 1'b0;
        end
    end

    // Near-limit alert, judged on the updated flags.
    assign n_alert = (w_t <= chcu_pkg::CMP_W'(i_thresh.temp_alert_lo) && w_t > w_tlo && !n_heat)
                  || (w_t >= chcu_pkg::CMP_W'(i_thresh.temp_alert_hi) && w_t < w_thi && !n_cool)
                  || (w_h <= chcu_pkg::CMP_W'(i_thresh.humid_alert) && w_h > w_hlo && !n_irr);

    // Flag state, which also forms the drive-flag part of the result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irr  <= 1'b0;
            r_cool <= 1'b0;
            r_heat <= 1'b0;
        end else if (i_load) begin
            r_irr  <= n_irr;
            r_cool <= n_cool;
            r_heat <= n_heat;
        end
    end

    // Remaining result payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_alert        <= n_alert;
            r_temp_scaled  <= chcu_pkg::FIELD_W'(i_temp);
            r_humid_scaled <= chcu_pkg::FIELD_W'(i_humid);
        end
    end

    assign o_irrigate_on  = r_irr;
    assign o_cool_on      = r_cool;
    assign o_heat_on      = r_heat;
    assign o_alert_on     = r_alert;
    assign o_temp_scaled  = r_temp_scaled;
    assign o_humid_scaled = r_humid_scaled;

endmodule

`default_nettype wire

### rtl/core/climate_hysteresis_controller_unit.sv
// Climate hysteresis controller.
// Input channel: i_valid, o_stall and one word of two raw 12-bit samples,
// i_temp_sample and i_humid_sample. A word is taken when i_valid is high and
// o_stall is low. Output channel: o_valid, i_stall and one result word of
// three drive flags, the alert flag and both scaled readings.
// The four 7-bit limits are written through i_cfg_we, i_cfg_idx and
// i_cfg_data; the user must do so only while no word is in flight (not enforced).
// An accepted word passes each stage in turn; the result register sets o_valid.
// One word can be taken every cycle while o_stall is low: a four-stage pipeline
// (input register, scaling multiply, reciprocal multiply, hysteresis and result
// register) holds up to four words; derived switching points sit in registers.
// While the receiver stalls, the result register holds its word and earlier
// stages keep filling; o_stall rises only once every stage is occupied.
// Reset (synchronous, active low) empties the pipeline, turns all three
// drives off and loads the default limits.
`default_nettype none

`include "climate_hysteresis_controller_unit_assert.svh"

module climate_hysteresis_controller_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [chcu_pkg::SAMPLE_W-1:0]  i_temp_sample,
    input  wire logic [chcu_pkg::SAMPLE_W-1:0]  i_humid_sample,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_irrigate_on,
    output logic                                o_cool_on,
    output logic                                o_heat_on,
    output logic                                o_alert_on,
    output logic [chcu_pkg::FIELD_W-1:0]        o_temp_scaled,
    output logic [chcu_pkg::FIELD_W-1:0]        o_humid_scaled,
    input  wire logic                           i_cfg_we,
    input  wire logic [chcu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [chcu_pkg::LIMIT_W-1:0]   i_cfg_data
);

    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               r_vo;
    logic               w_rdy1;
    logic               w_rdy2;
    logic               w_rdy3;
    logic               w_rdy4;
    logic               w_load;
    chcu_pkg::t_pipe_en w_en;
    chcu_pkg::t_thresh  w_thresh;
    logic [chcu_pkg::RD_W-1:0] w_temp;
    logic [chcu_pkg::RD_W-1:0] w_humid;

    // Ready chain: a stage may load when it is empty or its word moves on.
    assign w_rdy4  = !r_vo || !i_stall;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign w_en.s1 = i_valid && w_rdy1;
    assign w_en.s2 = r_v1 && w_rdy2;
    assign w_en.s3 = r_v2 && w_rdy3;
    assign w_load  = r_v3 && w_rdy4;
    assign o_stall = !w_rdy1;
    assign o_valid = r_vo;

    // Stage occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_vo <= r_v3;
            end
        end
    end

    // Scaling pipelines for both samples.
    chcu_scale u_temp_scale (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_raw    (i_temp_sample),
        .o_scaled (w_temp)
    );

    chcu_scale u_humid_scale (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_raw    (i_humid_sample),
        .o_scaled (w_humid)
    );

    // Limit registers and switching points.
    chcu_limits u_limits (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_thresh   (w_thresh)
    );

    // Hysteresis flags and result register.
    chcu_decide u_decide (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_load),
        .i_temp         (w_temp),
        .i_humid        (w_humid),
        .i_thresh       (w_thresh),
        .o_irrigate_on  (o_irrigate_on),
        .o_cool_on      (o_cool_on),
        .o_heat_on      (o_heat_on),
        .o_alert_on     (o_alert_on),
        .o_temp_scaled  (o_temp_scaled),
        .o_humid_scaled (o_humid_scaled)
    );

    // An empty result register never holds back the input.
    `CHCU_ASSERT_NOW(a_empty_out_no_stall, i_clk, i_rst_n, !r_vo, !o_stall)
    // Input stalls only when every stage is full and the receiver stalls.
    `CHCU_ASSERT_NOW(a_stall_only_full, i_clk, i_rst_n, o_stall, r_v1 && r_v2 && r_v3 && r_vo && i_stall)
    // An accepted word occupies the input stage on the next edge.
    `CHCU_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, i_valid && !o_stall, r_v1)
    // A word in the last scaling stage reaches the output unless it is blocked.
    `CHCU_ASSERT_NEXT(a_s3_moves_out, i_clk, i_rst_n, r_v3 && !(r_vo && i_stall), r_vo)

endmodule

`default_nettype wire

### test/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEMS_PER_PH = 65;
    localparam int NUM_PHASES   = 6;
    localparam int NUM_DIRECTED = 19;
    localparam int HOLD_CYCLES  = 50;
    localparam int BURST_WORDS  = 16;

    // One result word as the block presents it.
    typedef struct packed {
        logic                           irrigate;
        logic                           cool;
        logic                           heat;
        logic                           alert;
        logic [chcu_pkg::FIELD_W-1:0]   temp;
        logic [chcu_pkg::FIELD_W-1:0]   humid;
    } t_drive_word;

    // One directed row: raw samples, and a hand-computed word where one is given.
    typedef struct packed {
        logic [chcu_pkg::SAMPLE_W-1:0]  temp_raw;
        logic [chcu_pkg::SAMPLE_W-1:0]  humid_raw;
        logic                           known;
        t_drive_word                    want;
    } t_stim_row;

    localparam t_drive_word NO_WORD = '0;

    // Defaults hold: heat on at 10, cool on at 26, irrigation on at 60, upper humidity 83.
    localparam t_stim_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        // Both samples at zero and at full scale.
        {12'd0,    12'd0,    1'b1, {1'b1, 1'b0, 1'b1, 1'b0, 7'd0,  7'd0}},
        {12'd4095, 12'd4095, 1'b1, {1'b0, 1'b1, 1'b0, 1'b0, 7'd99, 7'd99}},
        // Rounding just below and just above one half.
        {12'd20,   12'd20,   1'b0, NO_WORD},
        {12'd21,   12'd21,   1'b0, NO_WORD},
        {12'd2047, 12'd2048, 1'b0, NO_WORD},
        // Cooling: on at the limit, held inside the band, off below it.
        {12'd1075, 12'd2895, 1'b0, NO_WORD},
        {12'd951,  12'd2895, 1'b0, NO_WORD},
        {12'd910,  12'd2895, 1'b0, NO_WORD},
        {12'd869,  12'd2895, 1'b0, NO_WORD},
        // Heating and irrigation on, then held, then off.
        {12'd414,  12'd2482, 1'b0, NO_WORD},
        {12'd579,  12'd2895, 1'b0, NO_WORD},
        {12'd620,  12'd3143, 1'b0, NO_WORD},
        {12'd496,  12'd3185, 1'b0, NO_WORD},
        // Near-limit alerts on both readings.
        {12'd993,  12'd2606, 1'b0, NO_WORD},
        {12'd455,  12'd2523, 1'b0, NO_WORD},
        // Opposite extremes and alternating bit patterns.
        {12'd4095, 12'd0,    1'b0, NO_WORD},
        {12'd0,    12'd4095, 1'b0, NO_WORD},
        {12'd2730, 12'd1365, 1'b0, NO_WORD},
        {12'd1365, 12'd2730, 1'b0, NO_WORD}
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic [chcu_pkg::SAMPLE_W-1:0]  i_temp_sample;
    logic [chcu_pkg::SAMPLE_W-1:0]  i_humid_sample;
    logic                           o_valid;
    logic                           i_stall;
    logic                           o_irrigate_on;
    logic                           o_cool_on;
    logic                           o_heat_on;
    logic                           o_alert_on;
    logic [chcu_pkg::FIELD_W-1:0]   o_temp_scaled;
    logic [chcu_pkg::FIELD_W-1:0]   o_humid_scaled;
    logic                           i_cfg_we;
    logic [chcu_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [chcu_pkg::LIMIT_W-1:0]   i_cfg_data;

    // Shadow copy of the limits and the three drives.
    logic [chcu_pkg::LIMIT_W-1:0]   lim_temp_low;
    logic [chcu_pkg::LIMIT_W-1:0]   lim_temp_high;
    logic [chcu_pkg::LIMIT_W-1:0]   lim_humid_low;
    logic [chcu_pkg::LIMIT_W-1:0]   lim_humid_high;
    bit                             irrigating;
    bit                             cooling;
    bit                             heating;

    t_drive_word                    pending_words[$];
    int                             mismatch_count;
    int                             cycle_count;
    int                             send_idle_pct;
    int                             recv_idle_pct;
    int                             burst_left;
    bit                             hold_req;

    climate_hysteresis_controller_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_temp_sample  (i_temp_sample),
        .i_humid_sample (i_humid_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_irrigate_on  (o_irrigate_on),
        .o_cool_on      (o_cool_on),
        .o_heat_on      (o_heat_on),
        .o_alert_on     (o_alert_on),
        .o_temp_scaled  (o_temp_scaled),
        .o_humid_scaled (o_humid_scaled),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Raw reading to 0..99, rounded half up and saturated.
    function automatic int scale_raw(logic [chcu_pkg::SAMPLE_W-1:0] raw);
        int s;
        s = (int'(raw) * int'(chcu_pkg::READING_TOP) + int'(chcu_pkg::SAMPLE_FULL_SCALE) / 2)
            / int'(chcu_pkg::SAMPLE_FULL_SCALE);
        return (s > int'(chcu_pkg::READING_TOP)) ? int'(chcu_pkg::READING_TOP) : s;
    endfunction

    // Hysteresis update of the three drives and the alert for one sample pair.
    function automatic t_drive_word next_drive_word(logic [chcu_pkg::SAMPLE_W-1:0] traw,
                                                    logic [chcu_pkg::SAMPLE_W-1:0] hraw);
        int t, h, tlo, thi, hlo, hhi, tspan, hspan;
        bit alert;
        t_drive_word w;
        t     = scale_raw(traw);
        h     = scale_raw(hraw);
        tlo   = int'(lim_temp_low);
        thi   = int'(lim_temp_high);
        hlo   = int'(lim_humid_low);
        hhi   = int'(lim_humid_high);
        tspan = (thi >= tlo) ? thi - tlo : 0;
        hspan = (hhi >= hlo) ? hhi - hlo : 0;

        if (h <= hlo) begin
            irrigating = 1'b1;
        end else if (h >= hlo + hspan * 3 / 4) begin
            irrigating = 1'b0;
        end
        if (t >= thi) begin
            cooling = 1'b1;
        end else if (t < thi - tspan / 4) begin
            cooling = 1'b0;
        end
        if (t <= tlo) begin
            heating = 1'b1;
        end else if (t > tlo + tspan / 4) begin
            heating = 1'b0;
        end

        alert = (t <= thi - tspan * 9 / 10 && t > tlo && !heating) ||
                (t >= tlo + tspan * 9 / 10 && t < thi && !cooling) ||
                (h <= hhi - hspan * 9 / 10 && h > hlo && !irrigating);

        w.irrigate = irrigating;
        w.cool     = cooling;
        w.heat     = heating;
        w.alert    = alert;
        w.temp     = chcu_pkg::FIELD_W'(t);
        w.humid    = chcu_pkg::FIELD_W'(h);
        return w;
    endfunction

    // Raw sample that lands a few steps around a chosen reading.
    function automatic logic [chcu_pkg::SAMPLE_W-1:0] raw_near(int reading);
        int s, raw;
        s = reading + int'($urandom_range(6)) - 3;
        if (s < 0) s = 0;
        if (s > int'(chcu_pkg::READING_TOP)) s = int'(chcu_pkg::READING_TOP);
        raw = (s * int'(chcu_pkg::SAMPLE_FULL_SCALE) + 49) / int'(chcu_pkg::READING_TOP)
              + int'($urandom_range(40)) - 20;
        if (raw < 0) raw = 0;
        if (raw > 4095) raw = 4095;
        return chcu_pkg::SAMPLE_W'(raw);
    endfunction

    // Offer one word, wait until the block takes it, then record its expected result.
    task automatic offer_word(input logic [chcu_pkg::SAMPLE_W-1:0] traw,
                              input logic [chcu_pkg::SAMPLE_W-1:0] hraw,
                              input logic known, input t_drive_word want);
        t_drive_word predicted;
        if (burst_left == 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_temp_sample  <= traw;
        i_humid_sample <= hraw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = next_drive_word(traw, hraw);
        pending_words.push_back(known ? want : predicted);
        if (burst_left > 0) burst_left--;
    endtask

    // Random word: mostly readings near the switching points, some anywhere.
    task automatic offer_random_word();
        logic [chcu_pkg::SAMPLE_W-1:0] traw, hraw;
        int tlo, thi, hlo, hhi, tspan, hspan;
        tlo   = int'(lim_temp_low);
        thi   = int'(lim_temp_high);
        hlo   = int'(lim_humid_low);
        hhi   = int'(lim_humid_high);
        tspan = (thi >= tlo) ? thi - tlo : 0;
        hspan = (hhi >= hlo) ? hhi - hlo : 0;
        if ($urandom_range(99) < 25) begin
            traw = chcu_pkg::SAMPLE_W'($urandom_range(4095));
            hraw = chcu_pkg::SAMPLE_W'($urandom_range(4095));
        end else begin
            case ($urandom_range(3))
                0: traw = raw_near(tlo);
                1: traw = raw_near(thi);
                2: traw = raw_near(tlo + tspan / 4);
                default: traw = raw_near(thi - tspan / 4);
            endcase
            case ($urandom_range(3))
                0: hraw = raw_near(hlo);
                1: hraw = raw_near(hhi);
                2: hraw = raw_near(hlo + hspan * 3 / 4);
                default: hraw = raw_near(hhi - hspan * 9 / 10);
            endcase
        end
        offer_word(traw, hraw, 1'b0, NO_WORD);
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
    endtask

    // Write all four limits while the pipeline is empty.
    task automatic load_limits(input logic [chcu_pkg::LIMIT_W-1:0] tlo,
                               input logic [chcu_pkg::LIMIT_W-1:0] thi,
                               input logic [chcu_pkg::LIMIT_W-1:0] hlo,
                               input logic [chcu_pkg::LIMIT_W-1:0] hhi);
        logic [chcu_pkg::CFG_IDX_W-1:0] idx;
        logic [chcu_pkg::LIMIT_W-1:0] val;
        drain_results();
        repeat (4) @(posedge i_clk);
        for (int r = 0; r < 4; r++) begin
            case (r)
                0: begin idx = chcu_pkg::CFG_TEMP_LOW;   val = tlo; end
                1: begin idx = chcu_pkg::CFG_TEMP_HIGH;  val = thi; end
                2: begin idx = chcu_pkg::CFG_HUMID_LOW;  val = hlo; end
                default: begin idx = chcu_pkg::CFG_HUMID_HIGH; val = hhi; end
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= val;
            @(posedge i_clk);
            case (idx)
                chcu_pkg::CFG_TEMP_LOW:   lim_temp_low   = val;
                chcu_pkg::CFG_TEMP_HIGH:  lim_temp_high  = val;
                chcu_pkg::CFG_HUMID_LOW:  lim_humid_low  = val;
                default:                  lim_humid_high = val;
            endcase
        end
        i_cfg_we <= 1'b0;
        // Let the switching points settle after the last write.
        repeat (3) @(posedge i_clk);
    endtask

    // Result side: compare each accepted word and pick the next stall value.
    initial begin
        int hold_left;
        t_drive_word exp_w;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_words.size() == 0) begin
                    $display("%0t: result word with nothing expected", $time);
                    mismatch_count++;
                end else begin
                    exp_w = pending_words.pop_front();
                    if (o_irrigate_on !== exp_w.irrigate) begin
                        $display("%0t: irrigate_on expected %0b actual %0b",
                                 $time, exp_w.irrigate, o_irrigate_on);
                        mismatch_count++;
                    end
                    if (o_cool_on !== exp_w.cool) begin
                        $display("%0t: cool_on expected %0b actual %0b",
                                 $time, exp_w.cool, o_cool_on);
                        mismatch_count++;
                    end
                    if (o_heat_on !== exp_w.heat) begin
                        $display("%0t: heat_on expected %0b actual %0b",
                                 $time, exp_w.heat, o_heat_on);
                        mismatch_count++;
                    end
                    if (o_alert_on !== exp_w.alert) begin
                        $display("%0t: alert_on expected %0b actual %0b",
                                 $time, exp_w.alert, o_alert_on);
                        mismatch_count++;
                    end
                    if (o_temp_scaled !== exp_w.temp) begin
                        $display("%0t: temp_scaled expected %0d actual %0d",
                                 $time, exp_w.temp, o_temp_scaled);
                        mismatch_count++;
                    end
                    if (o_humid_scaled !== exp_w.humid) begin
                        $display("%0t: humid_scaled expected %0d actual %0d",
                                 $time, exp_w.humid, o_humid_scaled);
                        mismatch_count++;
                    end
                end
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Main sequence: reset, directed rows, then random phases over several limit sets.
    initial begin
        mismatch_count = 0;
        burst_left     = 0;
        hold_req       = 1'b0;
        send_idle_pct  = 7;
        recv_idle_pct  = 64;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_temp_sample  <= '0;
        i_humid_sample <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= chcu_pkg::CFG_TEMP_LOW;
        i_cfg_data     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        lim_temp_low   = chcu_pkg::RST_TEMP_LOW;
        lim_temp_high  = chcu_pkg::RST_TEMP_HIGH;
        lim_humid_low  = chcu_pkg::RST_HUMID_LOW;
        lim_humid_high = chcu_pkg::RST_HUMID_HIGH;
        irrigating     = 1'b0;
        cooling        = 1'b0;
        heating        = 1'b0;
        @(posedge i_clk);

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            offer_word(DIRECTED_ROWS[r].temp_raw, DIRECTED_ROWS[r].humid_raw,
                       DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: ;
                1: load_limits(7'd0, 7'd127, 7'd0, 7'd127);
                2: load_limits(7'd127, 7'd0, 7'd127, 7'd0);
                3: load_limits(7'd20, 7'd40, 7'd30, 7'd90);
                4: load_limits(7'd0, 7'd0, 7'd99, 7'd99);
                default: load_limits(7'($urandom_range(127)), 7'($urandom_range(127)),
                                     7'($urandom_range(127)), 7'($urandom_range(127)));
            endcase
            // Sender dense and receiver busy, then the reverse, then no idling.
            if (ph < 2) begin
                send_idle_pct = 7;
                recv_idle_pct = 64;
            end else if (ph < 4) begin
                send_idle_pct = 64;
                recv_idle_pct = 7;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < ITEMS_PER_PH; n++) begin
                if (ph == 1 && n == 30) begin
                    drain_results();
                end
                if (ph == 3 && n == 20) begin
                    // Long receiver hold while words keep coming back to back.
                    hold_req   = 1'b1;
                    burst_left = BURST_WORDS;
                end
                offer_random_word();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
